### hdl/url_percent_encoder_unit_assert.svh
// Assertion macros used by the checker file of the encoder unit.
`ifndef URL_PERCENT_ENCODER_UNIT_ASSERT_SVH
`define URL_PERCENT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define UPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("encoder check failed");

// Next-cycle implication, off while reset is high.
`define UPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("encoder check failed");

`endif

### hdl/upe_pkg.sv
// Shared types, constants and functions of the URL percent-encoder.
package upe_pkg;

  localparam logic [15:0] CAP_RESET   = 16'd12288;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_ESCAPE = 2'd1,
    KIND_ERROR  = 2'd2
  } job_kind_t;

  // One classified source byte, waiting to be expanded by the back end.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       eos;
  } job_t;

  function automatic logic passes_through(input logic [7:0] b);
    passes_through = b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                               8'h2D, 8'h5F, 8'h7E, 8'h2E, 8'h2F};
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_digit = 8'h30 + {4'd0, n};
    end else begin
      hex_digit = 8'h37 + {4'd0, n};
    end
  endfunction

endpackage

### hdl/upe_queue.sv
// Small job queue between the classifying front end and the emitting back end.
module upe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upe_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output upe_pkg::job_t head
);

  upe_pkg::job_t                 slots [upe_pkg::QUEUE_DEPTH];
  logic [upe_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [upe_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [upe_pkg::QUEUE_AW:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count == (upe_pkg::QUEUE_AW+1)'(upe_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/upe_front.sv
// Front end: accepts source bytes, checks room and queues one job per byte, none once a string has overflowed.
module upe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_in,
  input  logic          end_of_string,
  input  logic          queue_full,
  output logic          push,
  output upe_pkg::job_t push_job
);

  logic [15:0] buffer_capacity;
  logic [15:0] output_position;
  logic        error_latched;
  logic        accept;
  logic        plain;
  logic [16:0] need_end;
  logic        no_room;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign plain    = upe_pkg::passes_through(char_in);
  assign need_end = {1'b0, output_position} + (plain ? 17'd2 : 17'd4);
  assign no_room  = need_end > {1'b0, buffer_capacity};
  assign push     = accept && !error_latched;

  always_comb begin
    push_job.data = char_in;
    push_job.eos  = end_of_string;
    if (no_room) begin
      push_job.kind = upe_pkg::KIND_ERROR;
    end else if (plain) begin
      push_job.kind = upe_pkg::KIND_PLAIN;
    end else begin
      push_job.kind = upe_pkg::KIND_ESCAPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= upe_pkg::CAP_RESET;
      output_position <= '0;
      error_latched   <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_capacity <= cfg_wdata;
      end
      if (accept) begin
        if (end_of_string) begin
          // string ends here either way: next one starts clean
          output_position <= '0;
          error_latched   <= 1'b0;
        end else if (!error_latched) begin
          if (no_room) begin
            error_latched <= 1'b1;
          end else if (plain) begin
            output_position <= output_position + 16'd1;
          end else begin
            output_position <= output_position + 16'd3;
          end
        end
      end
    end
  end

endmodule

### hdl/upe_back.sv
// Back end: expands queued jobs into output bytes, one per cycle while out_stall is low.
module upe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_not_empty,
  input  upe_pkg::job_t queue_head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          last_out,
  output logic          overflow_error
);

  upe_pkg::job_t job;
  logic          job_valid;
  logic [1:0]    step;
  logic [1:0]    final_step;
  logic [7:0]    gen_byte;
  logic          gen_last;
  logic          gen_err;
  logic          out_load;
  logic          job_take;

  always_comb begin
    gen_byte   = upe_pkg::CHAR_NUL;
    gen_last   = 1'b0;
    gen_err    = 1'b0;
    final_step = 2'd0;
    case (job.kind)
      upe_pkg::KIND_PLAIN: begin
        final_step = job.eos ? 2'd1 : 2'd0;
        if (step == 2'd0) begin
          gen_byte = job.data;
        end else begin
          gen_last = 1'b1;
        end
      end
      upe_pkg::KIND_ESCAPE: begin
        final_step = job.eos ? 2'd3 : 2'd2;
        case (step)
          2'd0:    gen_byte = upe_pkg::CHAR_PERCENT;
          2'd1:    gen_byte = upe_pkg::hex_digit(job.data[7:4]);
          2'd2:    gen_byte = upe_pkg::hex_digit(job.data[3:0]);
          default: gen_last = 1'b1;
        endcase
      end
      upe_pkg::KIND_ERROR: begin
        gen_last = 1'b1;
        gen_err  = 1'b1;
      end
      default: begin
        gen_last = 1'b1;
      end
    endcase
  end

  assign out_load = job_valid && (!out_valid || !out_stall);
  assign job_take = !job_valid || (out_load && (step == final_step));
  assign pop      = job_take && queue_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        job_valid <= queue_not_empty;
        step      <= '0;
      end else if (out_load) begin
        step <= step + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= queue_head;
    end
    if (out_load) begin
      out_byte       <= gen_byte;
      last_out       <= gen_last;
      overflow_error <= gen_err;
    end
  end

endmodule

### hdl/url_percent_encoder_unit.sv
// URL percent-encoder: letters, digits and - _ ~ . / pass through, every other
// byte becomes '%' plus two upper-case hex digits, and each string closes with
// a zero terminator marked last. Output is counted against buffer_capacity
// with one byte kept for the terminator; a byte that would not fit yields one
// error transaction (byte 0, last_out and overflow_error high) and the rest of
// that string is swallowed without output. The front end takes one source
// byte per cycle while the four-entry job queue has room; the back end sends
// one output byte per cycle while out_stall is low, so the output port sets
// the sustained rate: a pass-through byte yields one output byte, an escaped
// byte three, the final byte one more for the terminator and an error one,
// i.e. 1 to 4 output bytes per queued source byte. A source byte passes
// through the job queue, the back end's job register and the output register.
// buffer_capacity (reset 12288) may be written only while the unit is idle.
module url_percent_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration: capacity in bytes, terminator included
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // source byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_string,
  // encoded byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_out,
  output logic        overflow_error
);

  // front end -> queue
  logic          push;
  upe_pkg::job_t push_job;
  logic          queue_full;
  // queue -> back end
  logic          queue_not_empty;
  upe_pkg::job_t queue_head;
  logic          pop;

  // Classify each byte and run the room check; the position and capacity state lives here.
  upe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .queue_full    (queue_full),
    .push          (push),
    .push_job      (push_job)
  );

  // Decouples input acceptance from the multi-byte expansion.
  upe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  // Expand each job into 1..4 output transactions through an output register.
  upe_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .queue_head      (queue_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .last_out        (last_out),
    .overflow_error  (overflow_error)
  );

endmodule

### hdl/url_percent_encoder_unit_checker.sv
// Port-level checker for the encoder unit, bound to the top level.
`include "url_percent_encoder_unit_assert.svh"

module upe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_out,
  input logic       overflow_error
);

  `UPE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `UPE_ASSERT_IMPLY(a_err_last, clk, rst, out_valid && overflow_error, last_out)
  `UPE_ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && overflow_error, out_byte == 8'h00)
  `UPE_ASSERT_IMPLY(a_body_nonzero, clk, rst, out_valid && !last_out, out_byte != 8'h00)

endmodule

bind url_percent_encoder_unit upe_checker u_upe_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .last_out       (last_out),
  .overflow_error (overflow_error)
);
